[src/skc_pkg.sv]
// ============================================================================
// skc_pkg
// Shared types, register indexes, command codes and lookup tables of the
// soft-knee compressor.
// ============================================================================
package skc_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] CFG_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_INV_RATIO = 3'd1;
    localparam logic [2:0] CFG_KNEE      = 3'd2;
    localparam logic [2:0] CFG_INV_KNEE  = 3'd3;
    localparam logic [2:0] CFG_MAKEUP    = 3'd4;
    localparam logic [2:0] CFG_ATTACK    = 3'd5;
    localparam logic [2:0] CFG_RELEASE   = 3'd6;
    localparam logic [2:0] CFG_LINK      = 3'd7;

    localparam int CFG_DATA_WIDTH = 17;

    // Fixed-point constants.
    localparam logic [22:0] DB_PER_LOG2 = 23'd394566;
    localparam logic [22:0] LOG2_PER_DB = 23'd2786635;
    localparam logic signed [15:0] ZERO_LEVEL_DB = -16'sd25600;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_NORM,
        OP_LOG_MUL,
        OP_LOG_SET,
        OP_DB_MUL,
        OP_DB_SET,
        OP_ENV_MUL0,
        OP_ENV_MUL1,
        OP_ENV_SET,
        OP_CRV_MUL,
        OP_CRV_SET,
        OP_KNEE_MUL0,
        OP_KNEE_MUL1,
        OP_KNEE_SET,
        OP_GAIN_SET,
        OP_EXP_MUL,
        OP_EXP_SET,
        OP_MANT_MUL,
        OP_MANT_SET,
        OP_LEFT_MUL,
        OP_LEFT_SET,
        OP_RIGHT_MUL,
        OP_RIGHT_SET,
        OP_STORE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] step;
    } cmd_t;

    typedef struct packed {
        logic knee;
        logic linked;
    } status_t;

    // log2(1 + i/16) in Q1.16.
    function automatic logic [16:0] log_entry(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:  v = 17'd0;
            5'd1:  v = 17'd5732;
            5'd2:  v = 17'd11136;
            5'd3:  v = 17'd16248;
            5'd4:  v = 17'd21098;
            5'd5:  v = 17'd25711;
            5'd6:  v = 17'd30109;
            5'd7:  v = 17'd34312;
            5'd8:  v = 17'd38336;
            5'd9:  v = 17'd42196;
            5'd10: v = 17'd45904;
            5'd11: v = 17'd49472;
            5'd12: v = 17'd52911;
            5'd13: v = 17'd56229;
            5'd14: v = 17'd59434;
            5'd15: v = 17'd62534;
            5'd16: v = 17'd65536;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // 2^(i/16) in Q16.
    function automatic logic [17:0] exp_entry(input logic [4:0] i);
        logic [17:0] v;
        case (i)
            5'd0:  v = 18'd65536;
            5'd1:  v = 18'd68438;
            5'd2:  v = 18'd71468;
            5'd3:  v = 18'd74632;
            5'd4:  v = 18'd77936;
            5'd5:  v = 18'd81386;
            5'd6:  v = 18'd84990;
            5'd7:  v = 18'd88752;
            5'd8:  v = 18'd92682;
            5'd9:  v = 18'd96785;
            5'd10: v = 18'd101070;
            5'd11: v = 18'd105545;
            5'd12: v = 18'd110218;
            5'd13: v = 18'd115098;
            5'd14: v = 18'd120194;
            5'd15: v = 18'd125515;
            5'd16: v = 18'd131072;
            default: v = 18'd65536;
        endcase
        return v;
    endfunction

endpackage

[src/skc_ctrl.sv]
// ============================================================================
// skc_ctrl
// Sequencer of the compressor: steps the datapath through detection,
// envelope, knee curve and gain, and owns the output valid flag.
// ============================================================================
module skc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  skc_pkg::status_t status,
    output skc_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_NORM,
        S_LOG_MUL,
        S_LOG_SET,
        S_DB_MUL,
        S_DB_SET,
        S_ENV_MUL0,
        S_ENV_MUL1,
        S_ENV_SET,
        S_CRV_MUL,
        S_CRV_SET,
        S_KNEE_MUL0,
        S_KNEE_MUL1,
        S_KNEE_SET,
        S_GAIN_SET,
        S_EXP_MUL,
        S_EXP_SET,
        S_MANT_MUL,
        S_MANT_SET,
        S_LEFT_MUL,
        S_LEFT_SET,
        S_RIGHT_MUL,
        S_RIGHT_SET,
        S_STORE
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       store;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign store     = (state_reg == S_STORE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd.op     = skc_pkg::OP_NONE;
        cmd.step   = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = skc_pkg::OP_LOAD;
                    step_next  = 3'd0;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                cmd.op    = skc_pkg::OP_NORM;
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd4)
                begin
                    state_next = S_LOG_MUL;
                end
            end
            S_LOG_MUL:   begin cmd.op = skc_pkg::OP_LOG_MUL;   state_next = S_LOG_SET;   end
            S_LOG_SET:   begin cmd.op = skc_pkg::OP_LOG_SET;   state_next = S_DB_MUL;    end
            S_DB_MUL:    begin cmd.op = skc_pkg::OP_DB_MUL;    state_next = S_DB_SET;    end
            S_DB_SET:    begin cmd.op = skc_pkg::OP_DB_SET;    state_next = S_ENV_MUL0;  end
            S_ENV_MUL0:  begin cmd.op = skc_pkg::OP_ENV_MUL0;  state_next = S_ENV_MUL1;  end
            S_ENV_MUL1:  begin cmd.op = skc_pkg::OP_ENV_MUL1;  state_next = S_ENV_SET;   end
            S_ENV_SET:   begin cmd.op = skc_pkg::OP_ENV_SET;   state_next = S_CRV_MUL;   end
            S_CRV_MUL:   begin cmd.op = skc_pkg::OP_CRV_MUL;   state_next = S_CRV_SET;   end
            S_CRV_SET:
            begin
                cmd.op     = skc_pkg::OP_CRV_SET;
                state_next = status.knee ? S_KNEE_MUL0 : S_GAIN_SET;
            end
            S_KNEE_MUL0: begin cmd.op = skc_pkg::OP_KNEE_MUL0; state_next = S_KNEE_MUL1; end
            S_KNEE_MUL1: begin cmd.op = skc_pkg::OP_KNEE_MUL1; state_next = S_KNEE_SET;  end
            S_KNEE_SET:  begin cmd.op = skc_pkg::OP_KNEE_SET;  state_next = S_GAIN_SET;  end
            S_GAIN_SET:  begin cmd.op = skc_pkg::OP_GAIN_SET;  state_next = S_EXP_MUL;   end
            S_EXP_MUL:   begin cmd.op = skc_pkg::OP_EXP_MUL;   state_next = S_EXP_SET;   end
            S_EXP_SET:   begin cmd.op = skc_pkg::OP_EXP_SET;   state_next = S_MANT_MUL;  end
            S_MANT_MUL:  begin cmd.op = skc_pkg::OP_MANT_MUL;  state_next = S_MANT_SET;  end
            S_MANT_SET:  begin cmd.op = skc_pkg::OP_MANT_SET;  state_next = S_LEFT_MUL;  end
            S_LEFT_MUL:  begin cmd.op = skc_pkg::OP_LEFT_MUL;  state_next = S_LEFT_SET;  end
            S_LEFT_SET:
            begin
                cmd.op     = skc_pkg::OP_LEFT_SET;
                state_next = status.linked ? S_RIGHT_MUL : S_STORE;
            end
            S_RIGHT_MUL: begin cmd.op = skc_pkg::OP_RIGHT_MUL; state_next = S_RIGHT_SET; end
            S_RIGHT_SET: begin cmd.op = skc_pkg::OP_RIGHT_SET; state_next = S_STORE;     end
            S_STORE:
            begin
                // The result register must be free before it is overwritten.
                if (store)
                begin
                    cmd.op     = skc_pkg::OP_STORE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (store)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[src/skc_datapath.sv]
// ============================================================================
// skc_datapath
// Configuration registers, envelope state and the arithmetic of the
// compressor around one shared signed multiplier with a registered product.
// ============================================================================
module skc_datapath #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  skc_pkg::cmd_t                          cmd,
    output skc_pkg::status_t                       status,
    input  logic                                   cfg_write,
    input  logic [2:0]                             cfg_index,
    input  logic [skc_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0]         left_sample,
    input  logic signed [SAMPLE_WIDTH-1:0]         right_sample,
    output logic signed [SAMPLE_WIDTH-1:0]         left_out,
    output logic signed [SAMPLE_WIDTH-1:0]         right_out,
    output logic [14:0]                            reduction_amount
);

    localparam int W = SAMPLE_WIDTH;
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    typedef enum logic [1:0] {
        RG_BELOW,
        RG_KNEE,
        RG_ABOVE
    } region_t;

    // Configuration and envelope state.
    logic signed [15:0] thr_reg;
    logic [16:0]        ir_reg;
    logic [12:0]        knee_reg;
    logic [15:0]        ik_reg;
    logic signed [13:0] mk_reg;
    logic [15:0]        attack_reg;
    logic [15:0]        release_reg;
    logic               link_reg;
    logic signed [15:0] env_reg;

    // Per-transaction working registers.
    logic signed [W-1:0] left_reg, right_reg;
    logic                mag_zero_reg;
    logic [31:0]         norm_reg;
    logic [4:0]          shift_reg;
    logic [21:0]         neg_reg;
    logic signed [15:0]  x_reg;
    logic [15:0]         coef_reg;
    logic signed [55:0]  acc_reg, prod_reg;
    region_t             region_reg;
    logic [16:0]         kf_reg;
    logic signed [19:0]  curve_reg;
    logic [14:0]         red_reg;
    logic signed [15:0]  g_reg;
    logic signed [5:0]   n_reg;
    logic [15:0]         frac_reg;
    logic [17:0]         mant_reg;
    logic signed [W-1:0] lres_reg, rres_reg;
    logic signed [W-1:0] left_out_reg, right_out_reg;
    logic [14:0]         red_out_reg;

    // Combinational helpers.
    logic [W-1:0]        mag_l, mag_r, mag_sel;
    logic [31:0]         norm_mask;
    logic [4:0]          norm_amt;
    logic [3:0]          log_idx;
    logic [11:0]         log_rem;
    logic [16:0]         log_diff, log_frac;
    logic [4:0]          exp_e;
    logic signed [7:0]   e_off;
    logic signed [24:0]  l_val;
    logic signed [55:0]  db_sum;
    logic [17:0]         db_q;
    logic signed [15:0]  x_val;
    logic signed [17:0]  t18, half18, start18, end18, env18, d18;
    logic [13:0]         d_val;
    logic signed [16:0]  env_minus_t;
    logic signed [17:0]  ir_m;
    region_t             region_val;
    logic signed [55:0]  rnd_sum;
    logic signed [55:0]  env_sum;
    logic [21:0]         kf_raw;
    logic signed [20:0]  red_diff, g_sum;
    logic [17:0]         exp_diff;
    logic [3:0]          exp_idx;
    logic [11:0]         exp_rem;
    logic signed [32:0]  mul_a;
    logic signed [22:0]  mul_b;
    logic                mul_en;
    logic signed [63:0]  v64, rnd64, shifted;
    logic [2:0]          lsh;
    logic [5:0]          rsh;
    logic signed [W-1:0] gained;

    assign status.knee   = (region_reg == RG_KNEE);
    assign status.linked = link_reg;

    assign left_out         = left_out_reg;
    assign right_out        = right_out_reg;
    assign reduction_amount = red_out_reg;

    // Detector magnitude; the most negative sample maps to 2^(W-1).
    always_comb
    begin
        mag_l   = left_sample[W-1] ? W'(-left_sample) : W'(left_sample);
        mag_r   = right_sample[W-1] ? W'(-right_sample) : W'(right_sample);
        mag_sel = (link_reg && (mag_r > mag_l)) ? mag_r : mag_l;
    end

    // Binary leading-one search: 16, 8, 4, 2, 1 bit steps.
    always_comb
    begin
        norm_amt = 5'd16 >> cmd.step;
        case (cmd.step)
            3'd0:    norm_mask = 32'hFFFF_0000;
            3'd1:    norm_mask = 32'hFF00_0000;
            3'd2:    norm_mask = 32'hF000_0000;
            3'd3:    norm_mask = 32'hC000_0000;
            default: norm_mask = 32'h8000_0000;
        endcase
    end

    // Log2 and dB conversion.
    always_comb
    begin
        log_idx  = norm_reg[30:27];
        log_rem  = norm_reg[26:15];
        log_diff = skc_pkg::log_entry({1'b0, log_idx} + 5'd1)
                   - skc_pkg::log_entry({1'b0, log_idx});
        log_frac = skc_pkg::log_entry({1'b0, log_idx}) + 17'(prod_reg[28:12]);
        exp_e    = 5'd31 - shift_reg;
        e_off    = $signed({3'b000, exp_e}) - 8'(W - 1);
        l_val    = $signed({e_off[7], e_off, 16'h0000}) + $signed({8'h00, log_frac});
        db_sum   = prod_reg + 56'sd8388608;
        db_q     = db_sum[41:24];
        if (mag_zero_reg)
        begin
            x_val = skc_pkg::ZERO_LEVEL_DB;
        end
        else if (db_q > 18'd32768)
        begin
            x_val = -16'sd32768;
        end
        else
        begin
            x_val = 16'(-$signed({1'b0, db_q}));
        end
    end

    // Knee geometry around the threshold.
    always_comb
    begin
        t18         = 18'(thr_reg);
        half18      = $signed({6'b000000, knee_reg[12:1]});
        start18     = t18 - half18;
        end18       = t18 + half18;
        env18       = 18'(env_reg);
        d18         = env18 - start18;
        d_val       = d18[13:0];
        env_minus_t = 17'(env_reg) - 17'(thr_reg);
        ir_m        = $signed({1'b0, ir_reg}) - 18'sd65536;
        if (env18 <= start18)
        begin
            region_val = RG_BELOW;
        end
        else if (env18 >= end18)
        begin
            region_val = RG_ABOVE;
        end
        else
        begin
            region_val = RG_KNEE;
        end
        env_sum  = acc_reg + prod_reg + 56'sd32768;
        rnd_sum  = prod_reg + 56'sd32768;
        kf_raw   = 22'((prod_reg + 56'sd128) >>> 8);
        red_diff = 21'(env_reg) - 21'(curve_reg);
        g_sum    = 21'(curve_reg) - 21'(env_reg) + 21'(mk_reg);
    end

    // Exponent table and gain shift.
    always_comb
    begin
        exp_idx  = frac_reg[15:12];
        exp_rem  = frac_reg[11:0];
        exp_diff = skc_pkg::exp_entry({1'b0, exp_idx} + 5'd1)
                   - skc_pkg::exp_entry({1'b0, exp_idx});
        v64      = 64'(prod_reg);
        lsh      = 3'(n_reg - 6'sd16);
        rsh      = 6'(6'sd16 - n_reg);
        rnd64    = (rsh == 6'd0) ? 64'sd0 : (64'sd1 <<< (rsh - 6'd1));
        if (n_reg > 6'sd16)
        begin
            shifted = v64 <<< lsh;
        end
        else
        begin
            shifted = (v64 + rnd64) >>> rsh;
        end
        if (shifted > SAT_HI)
        begin
            gained = W'(SAT_HI);
        end
        else if (shifted < SAT_LO)
        begin
            gained = W'(SAT_LO);
        end
        else
        begin
            gained = W'(shifted);
        end
    end

    // Operand selection of the shared multiplier.
    always_comb
    begin
        mul_a  = 33'sd0;
        mul_b  = 23'sd0;
        mul_en = 1'b1;
        case (cmd.op)
            skc_pkg::OP_LOG_MUL:
            begin
                mul_a = $signed({16'h0000, log_diff});
                mul_b = $signed({11'h000, log_rem});
            end
            skc_pkg::OP_DB_MUL:
            begin
                mul_a = $signed({11'h000, neg_reg});
                mul_b = $signed(skc_pkg::DB_PER_LOG2);
            end
            skc_pkg::OP_ENV_MUL0:
            begin
                mul_a = $signed({17'h00000, coef_reg});
                mul_b = 23'(env_reg);
            end
            skc_pkg::OP_ENV_MUL1:
            begin
                mul_a = $signed(33'd65536 - {17'h00000, coef_reg});
                mul_b = 23'(x_reg);
            end
            skc_pkg::OP_CRV_MUL:
            begin
                if (region_val == RG_ABOVE)
                begin
                    mul_a = 33'(env_minus_t);
                    mul_b = $signed({6'h00, ir_reg});
                end
                else
                begin
                    mul_a = $signed({19'h00000, d_val});
                    mul_b = $signed({7'h00, ik_reg});
                end
            end
            skc_pkg::OP_KNEE_MUL0:
            begin
                mul_a = $signed({19'h00000, d_val});
                mul_b = $signed({6'h00, kf_reg});
            end
            skc_pkg::OP_KNEE_MUL1:
            begin
                mul_a = prod_reg[32:0];
                mul_b = 23'(ir_m);
            end
            skc_pkg::OP_EXP_MUL:
            begin
                mul_a = 33'(g_reg);
                mul_b = $signed(skc_pkg::LOG2_PER_DB);
            end
            skc_pkg::OP_MANT_MUL:
            begin
                mul_a = $signed({15'h0000, exp_diff});
                mul_b = $signed({11'h000, exp_rem});
            end
            skc_pkg::OP_LEFT_MUL:
            begin
                mul_a = 33'(left_reg);
                mul_b = $signed({5'h00, mant_reg});
            end
            skc_pkg::OP_RIGHT_MUL:
            begin
                mul_a = 33'(right_reg);
                mul_b = $signed({5'h00, mant_reg});
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Configuration and envelope state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= -16'sd5120;
            ir_reg      <= 17'd16384;
            knee_reg    <= 13'd1536;
            ik_reg      <= 16'd10923;
            mk_reg      <= 14'sd0;
            attack_reg  <= 16'd65400;
            release_reg <= 16'd65522;
            link_reg    <= 1'b0;
            env_reg     <= 16'sd0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    skc_pkg::CFG_THRESHOLD: thr_reg     <= $signed(cfg_data[15:0]);
                    skc_pkg::CFG_INV_RATIO: ir_reg      <= cfg_data[16:0];
                    skc_pkg::CFG_KNEE:      knee_reg    <= cfg_data[12:0];
                    skc_pkg::CFG_INV_KNEE:  ik_reg      <= cfg_data[15:0];
                    skc_pkg::CFG_MAKEUP:    mk_reg      <= $signed(cfg_data[13:0]);
                    skc_pkg::CFG_ATTACK:    attack_reg  <= cfg_data[15:0];
                    skc_pkg::CFG_RELEASE:   release_reg <= cfg_data[15:0];
                    skc_pkg::CFG_LINK:      link_reg    <= cfg_data[0];
                    default:                link_reg    <= link_reg;
                endcase
            end
            if (cmd.op == skc_pkg::OP_ENV_SET)
            begin
                // Floor of the rounded sum over 2^16; the result fits 16 bits.
                env_reg <= $signed(env_sum[31:16]);
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        case (cmd.op)
            skc_pkg::OP_LOAD:
            begin
                left_reg     <= left_sample;
                right_reg    <= right_sample;
                norm_reg     <= 32'(mag_sel);
                shift_reg    <= 5'd0;
                mag_zero_reg <= (mag_sel == '0);
            end
            skc_pkg::OP_NORM:
            begin
                if ((norm_reg & norm_mask) == 32'h0)
                begin
                    norm_reg  <= norm_reg << norm_amt;
                    shift_reg <= shift_reg + norm_amt;
                end
            end
            skc_pkg::OP_LOG_SET:
            begin
                neg_reg <= (l_val > 25'sd0) ? 22'd0 : 22'(-l_val);
            end
            skc_pkg::OP_DB_SET:
            begin
                x_reg    <= x_val;
                coef_reg <= (x_val > env_reg) ? attack_reg : release_reg;
            end
            skc_pkg::OP_ENV_MUL1:
            begin
                acc_reg <= prod_reg;
            end
            skc_pkg::OP_CRV_MUL:
            begin
                region_reg <= region_val;
            end
            skc_pkg::OP_CRV_SET:
            begin
                if (region_reg == RG_ABOVE)
                begin
                    curve_reg <= 20'(thr_reg) + $signed(rnd_sum[35:16]);
                end
                else
                begin
                    curve_reg <= 20'(env_reg);
                end
                kf_reg <= (kf_raw > 22'd65536) ? 17'd65536 : kf_raw[16:0];
            end
            skc_pkg::OP_KNEE_SET:
            begin
                curve_reg <= 20'(env_reg)
                             + $signed(20'((prod_reg + (56'sd1 <<< 32)) >>> 33));
            end
            skc_pkg::OP_GAIN_SET:
            begin
                if (red_diff < 21'sd0)
                begin
                    red_reg <= 15'd0;
                end
                else if (red_diff > 21'sd32767)
                begin
                    red_reg <= 15'd32767;
                end
                else
                begin
                    red_reg <= red_diff[14:0];
                end
                if (g_sum < -21'sd32768)
                begin
                    g_reg <= -16'sd32768;
                end
                else if (g_sum > 21'sd32767)
                begin
                    g_reg <= 16'sd32767;
                end
                else
                begin
                    g_reg <= g_sum[15:0];
                end
            end
            skc_pkg::OP_EXP_SET:
            begin
                n_reg    <= $signed(rnd_sum[37:32]);
                frac_reg <= rnd_sum[31:16];
            end
            skc_pkg::OP_MANT_SET:
            begin
                mant_reg <= skc_pkg::exp_entry({1'b0, exp_idx}) + 18'(prod_reg[28:12]);
            end
            skc_pkg::OP_LEFT_SET:
            begin
                lres_reg <= gained;
            end
            skc_pkg::OP_RIGHT_SET:
            begin
                rres_reg <= gained;
            end
            skc_pkg::OP_STORE:
            begin
                left_out_reg  <= lres_reg;
                right_out_reg <= link_reg ? rres_reg : right_reg;
                red_out_reg   <= red_reg;
            end
            default:
            begin
                left_reg <= left_reg;
            end
        endcase
    end

endmodule

[src/soft_knee_compressor.sv]
// ============================================================================
// soft_knee_compressor
// Soft-knee feedforward stereo compressor with dB envelope, static curve,
// makeup gain and saturating outputs.
// ============================================================================
//
// Channel  | Handshake                    | Payload
// ---------+------------------------------+----------------------------------
// input    | in_valid / in_ready          | left_sample, right_sample
// output   | out_valid / out_ready        | left_out, right_out,
//          |                              | reduction_amount
// config   | cfg_write                    | cfg_index, cfg_data
//
// A transaction runs from acceptance to the result register through the
// sequencer states, with the knee states only inside the knee and the
// right-channel states only when stereo linked; the sequencer is back in
// idle before the next input is taken. Every log, envelope, knee,
// exponent and gain step passes through the one shared multiplier in turn.
// A new input is taken once the previous item has reached the result
// register, even while that result is still stalled by out_ready.
// Reset clears the envelope to 0 dB and loads the register defaults.
module soft_knee_compressor #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]     left_sample,
    input  logic signed [SAMPLE_WIDTH-1:0]     right_sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]     left_out,
    output logic signed [SAMPLE_WIDTH-1:0]     right_out,
    output logic [14:0]                        reduction_amount,
    input  logic                               cfg_write,
    input  logic [2:0]                         cfg_index,
    input  logic [skc_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);

    skc_pkg::cmd_t    cmd;
    skc_pkg::status_t status;

    skc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    skc_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .left_sample      (left_sample),
        .right_sample     (right_sample),
        .left_out         (left_out),
        .right_out        (right_out),
        .reduction_amount (reduction_amount)
    );

    // An accepted transaction keeps the sequencer busy on the next cycle.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("input still ready right after a transaction was accepted");

    // A new result is only presented once the sequencer is back to idle.
    a_idle_on_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready
    ) else $error("result presented while the sequencer is still busy");

    // The load command is only issued for an accepted transaction.
    a_load_on_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.op == skc_pkg::OP_LOAD) |-> (in_valid && in_ready)
    ) else $error("datapath loaded without an accepted transaction");

endmodule

[tb/sv/soft_knee_compressor_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// soft_knee_compressor_checker
// Watches the input and output channels of the compressor, predicts each
// result from the accepted samples and the current register settings, and
// compares every output transaction field by field.
// ============================================================================
module soft_knee_compressor_checker #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] left_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] right_sample,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] left_out,
    input  logic signed [SAMPLE_WIDTH-1:0] right_out,
    input  logic [14:0]                    reduction_amount,
    input  logic                           cfg_write,
    input  logic [2:0]                     cfg_index,
    input  logic [skc_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending_count,
    output int                             frame_count
);

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left;
        logic signed [SAMPLE_WIDTH-1:0] right;
        logic [14:0]                    reduction;
    } frame_t;

    localparam longint LOG_TAB [17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109,
        34312, 38336, 42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
    localparam longint EXP_TAB [17] = '{65536, 68438, 71468, 74632, 77936, 81386,
        84990, 88752, 92682, 96785, 101070, 105545, 110218, 115098, 120194,
        125515, 131072};

    logic signed [15:0] thresh_q;
    logic [16:0]        inv_ratio_q;
    logic [12:0]        knee_q;
    logic [15:0]        inv_knee_q;
    logic signed [13:0] makeup_q;
    logic [15:0]        attack_q;
    logic [15:0]        release_q;
    logic               link_q;
    longint             envelope_db;
    frame_t             expected_frames[$];

    function automatic longint floor_shift(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint magnitude_to_db(longint mag);
        int e;
        longint f, frac, l, db;
        int idx, rem;
        if (mag == 0)
            return -25600;
        e = 32;
        while (e > 0 && !mag[e])
            e--;
        f = (mag << (32 - e)) & 64'hFFFF_FFFF;
        idx = int'(f >> 28);
        rem = int'((f >> 16) & 12'hFFF);
        frac = LOG_TAB[idx] + (((LOG_TAB[idx + 1] - LOG_TAB[idx]) * rem) >>> 12);
        l = (e - (SAMPLE_WIDTH - 1)) * 65536 + frac;
        if (l > 0)
            l = 0;
        db = -(((-l) * 394566 + (64'd1 << 23)) >>> 24);
        return clip(db, -32768, 0);
    endfunction

    function automatic longint scale_sample(longint s, longint mant, longint n);
        longint hi, v;
        hi = (64'sd1 << (SAMPLE_WIDTH - 1)) - 1;
        v = s * mant;
        if (n > 16)
            v = v * (64'sd1 << (n - 16));
        else if (n < 16)
            v = floor_shift(v + (64'sd1 << (15 - n)), int'(16 - n));
        return clip(v, -hi - 1, hi);
    endfunction

    function automatic frame_t compress_frame(longint l, longint r);
        frame_t res;
        longint ml, mr, mag, x, c, t, ir, half, start, stop, curve, red, g, p, n;
        longint frac, mant, d, kf;
        int idx, rem;
        ml = l < 0 ? -l : l;
        mr = r < 0 ? -r : r;
        mag = (link_q && mr > ml) ? mr : ml;
        x = magnitude_to_db(mag);
        c = x > envelope_db ? attack_q : release_q;
        t = thresh_q;
        ir = inv_ratio_q;
        half = knee_q >> 1;
        start = t - half;
        stop = t + half;
        envelope_db = floor_shift(c * envelope_db + (65536 - c) * x + 32768, 16);
        if (envelope_db <= start)
            curve = envelope_db;
        else if (envelope_db >= stop)
            curve = t + floor_shift((envelope_db - t) * ir + 32768, 16);
        else
        begin
            d = envelope_db - start;
            kf = (d * inv_knee_q + 128) >>> 8;
            if (kf > 65536)
                kf = 65536;
            curve = envelope_db + floor_shift(d * kf * (ir - 65536) + (64'sd1 << 32), 33);
        end
        red = clip(envelope_db - curve, 0, 32767);
        g = clip(curve - envelope_db + makeup_q, -32768, 32767);
        p = floor_shift(g * 2786635 + 32768, 16);
        n = floor_shift(p, 16);
        frac = p - n * 65536;
        idx = int'(frac >> 12);
        rem = int'(frac & 12'hFFF);
        mant = EXP_TAB[idx] + (((EXP_TAB[idx + 1] - EXP_TAB[idx]) * rem) >>> 12);
        res.left = scale_sample(l, mant, n);
        res.right = link_q ? scale_sample(r, mant, n) : r;
        res.reduction = red[14:0];
        return res;
    endfunction

    assign pending_count = expected_frames.size();

    always @(posedge clk or negedge rst_n)
    begin
        frame_t want;
        if (!rst_n)
        begin
            thresh_q = -16'sd5120;
            inv_ratio_q = 17'd16384;
            knee_q = 13'd1536;
            inv_knee_q = 16'd10923;
            makeup_q = '0;
            attack_q = 16'd65400;
            release_q = 16'd65522;
            link_q = 1'b0;
            envelope_db = 0;
            fail_count = 0;
            frame_count = 0;
            expected_frames.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    skc_pkg::CFG_THRESHOLD: thresh_q = cfg_data[15:0];
                    skc_pkg::CFG_INV_RATIO: inv_ratio_q = cfg_data[16:0];
                    skc_pkg::CFG_KNEE:      knee_q = cfg_data[12:0];
                    skc_pkg::CFG_INV_KNEE:  inv_knee_q = cfg_data[15:0];
                    skc_pkg::CFG_MAKEUP:    makeup_q = cfg_data[13:0];
                    skc_pkg::CFG_ATTACK:    attack_q = cfg_data[15:0];
                    skc_pkg::CFG_RELEASE:   release_q = cfg_data[15:0];
                    skc_pkg::CFG_LINK:      link_q = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                frame_count++;
                if (expected_frames.size() == 0)
                begin
                    $error("unexpected output transaction");
                    fail_count++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (left_out !== want.left)
                    begin
                        $error("left_out: expected %0d, got %0d", want.left, left_out);
                        fail_count++;
                    end
                    if (right_out !== want.right)
                    begin
                        $error("right_out: expected %0d, got %0d", want.right, right_out);
                        fail_count++;
                    end
                    if (reduction_amount !== want.reduction)
                    begin
                        $error("reduction_amount: expected %0d, got %0d",
                               want.reduction, reduction_amount);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_frames.push_back(compress_frame(left_sample, right_sample));
        end
    end
endmodule

[tb/sv/soft_knee_compressor_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// soft_knee_compressor_test
// Drives stereo frames through the compressor under several register
// settings with random bursts and output stalls; the checker predicts
// and compares every result.
// ============================================================================
module soft_knee_compressor_test;

    localparam int SW = 24;
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_FRAMES = 1850;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [SW-1:0] left_sample;
    logic signed [SW-1:0] right_sample;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [SW-1:0] left_out;
    logic signed [SW-1:0] right_out;
    logic [14:0]          reduction_amount;
    logic                 cfg_write;
    logic [2:0]           cfg_index;
    logic [skc_pkg::CFG_DATA_WIDTH-1:0] cfg_data;
    int                   fail_count;
    int                   pending_count;
    int                   frame_count;
    int                   idle_cycles;
    int                   stall_mode;
    int                   sent_frames;

    soft_knee_compressor #(.SAMPLE_WIDTH(SW)) u_dut (.*);

    soft_knee_compressor_checker #(.SAMPLE_WIDTH(SW)) u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Output stalls follow their own mode, which changes now and then.
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 1) != 0);
            default: out_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_frame(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r);
        in_valid <= 1'b1;
        left_sample <= l;
        right_sample <= r;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        sent_frames++;
    endtask

    task automatic pause_input(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int value);
        in_valid <= 1'b0;
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[skc_pkg::CFG_DATA_WIDTH-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // Random level: any word, full scale of either sign, tiny, zero or scaled down.
    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return SW'($urandom);
            1: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            2: return $signed(24'($urandom_range(0, 255))) - 128;
            3: return 24'sd0;
            default: return SW'($urandom >>> $urandom_range(0, 22));
        endcase
    endfunction

    task automatic load_setting(input int k);
        case (k)
            0:
            begin
                write_reg(skc_pkg::CFG_THRESHOLD, -32768);
                write_reg(skc_pkg::CFG_INV_RATIO, 0);
                write_reg(skc_pkg::CFG_KNEE, 6144);
                write_reg(skc_pkg::CFG_INV_KNEE, 2731);
                write_reg(skc_pkg::CFG_MAKEUP, 6144);
                write_reg(skc_pkg::CFG_ATTACK, 0);
                write_reg(skc_pkg::CFG_RELEASE, 0);
                write_reg(skc_pkg::CFG_LINK, 1);
            end
            1:
            begin
                write_reg(skc_pkg::CFG_THRESHOLD, 0);
                write_reg(skc_pkg::CFG_INV_RATIO, 65536);
                write_reg(skc_pkg::CFG_KNEE, 0);
                write_reg(skc_pkg::CFG_INV_KNEE, 65535);
                write_reg(skc_pkg::CFG_MAKEUP, -6144);
                write_reg(skc_pkg::CFG_ATTACK, 65535);
                write_reg(skc_pkg::CFG_RELEASE, 65535);
                write_reg(skc_pkg::CFG_LINK, 0);
            end
            2:
            begin
                // Mismatched knee factor, so the knee fraction clamps.
                write_reg(skc_pkg::CFG_THRESHOLD, -3000);
                write_reg(skc_pkg::CFG_INV_RATIO, 8192);
                write_reg(skc_pkg::CFG_KNEE, 2560);
                write_reg(skc_pkg::CFG_INV_KNEE, 65535);
                write_reg(skc_pkg::CFG_MAKEUP, 1200);
                write_reg(skc_pkg::CFG_ATTACK, 20000);
                write_reg(skc_pkg::CFG_RELEASE, 60000);
                write_reg(skc_pkg::CFG_LINK, 1);
            end
            3:
            begin
                // Random ratio above the threshold, from full limiting to expansion.
                write_reg(skc_pkg::CFG_THRESHOLD, -6000);
                write_reg(skc_pkg::CFG_INV_RATIO, 65536 + 0);
                write_reg(skc_pkg::CFG_INV_RATIO, $urandom_range(0, 131071));
                write_reg(skc_pkg::CFG_KNEE, 256 * $urandom_range(1, 24));
                write_reg(skc_pkg::CFG_INV_KNEE, $urandom_range(0, 65535));
                write_reg(skc_pkg::CFG_MAKEUP, $urandom_range(0, 16383));
                write_reg(skc_pkg::CFG_ATTACK, $urandom_range(0, 65535));
                write_reg(skc_pkg::CFG_RELEASE, $urandom_range(0, 65535));
                write_reg(skc_pkg::CFG_LINK, $urandom_range(0, 1));
            end
            default:
            begin
                write_reg(skc_pkg::CFG_THRESHOLD, -$urandom_range(0, 32768));
                write_reg(skc_pkg::CFG_INV_RATIO, $urandom_range(0, 65536));
                write_reg(skc_pkg::CFG_KNEE,
                          $urandom_range(0, 1) ? 0 : $urandom_range(256, 6144));
                write_reg(skc_pkg::CFG_INV_KNEE, $urandom_range(0, 65535));
                write_reg(skc_pkg::CFG_MAKEUP, $urandom_range(0, 12288) - 6144);
                write_reg(skc_pkg::CFG_ATTACK, $urandom_range(0, 65535));
                write_reg(skc_pkg::CFG_RELEASE, $urandom_range(0, 65535));
                write_reg(skc_pkg::CFG_LINK, $urandom_range(0, 1));
            end
        endcase
    endtask

    initial
    begin
        int burst;
        rst_n = 1'b0;
        in_valid = 1'b0;
        left_sample = '0;
        right_sample = '0;
        cfg_write = 1'b0;
        cfg_index = skc_pkg::CFG_THRESHOLD;
        cfg_data = '0;
        out_ready = 1'b1;
        stall_mode = 0;
        idle_cycles = 0;
        sent_frames = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed frames at reset settings: extremes, silence, tiny levels.
        send_frame(24'sh7FFFFF, 24'sh800000);
        send_frame(24'sh800000, 24'sh7FFFFF);
        send_frame(24'sd0, 24'sd0);
        send_frame(24'sd1, -24'sd1);
        send_frame(-24'sd1, 24'sd0);
        send_frame(24'sh7FFFFF, 24'sd0);
        send_frame(24'sh155555, 24'shAAAAAA);
        send_frame(24'shAAAAAA, 24'sh555555);
        drain();
        load_setting(0);
        send_frame(24'sd0, 24'sh7FFFFF);
        send_frame(24'sh800000, 24'sd3);
        send_frame(24'sd2, 24'sh400000);
        send_frame(24'sh7FFFFF, 24'sh7FFFFF);
        drain();
        load_setting(1);
        send_frame(24'sh7FFFFF, 24'sh123456);
        send_frame(24'sd0, 24'sh800000);
        send_frame(24'sh400000, 24'shFFFFFF);
        drain();
        load_setting(2);
        for (int i = 0; i < 6; i++)
            send_frame(24'sh080000 << (i % 4), -24'sh040000);
        drain();

        for (int phase = 0; phase < 10; phase++)
        begin
            load_setting(phase < 3 ? phase : (phase == 3 ? 3 : 4));
            for (int i = 0; i < RANDOM_FRAMES / 10; )
            begin
                burst = $urandom_range(1, 30);
                for (int j = 0; j < burst && i < RANDOM_FRAMES / 10; j++, i++)
                    send_frame(pick_sample(), pick_sample());
                if ($urandom_range(0, 2) != 0)
                    pause_input($urandom_range(1, 40));
            end
            drain();
        end

        $display("Covered %0d frames (%0d results) over ten register settings,",
                 sent_frames, frame_count);
        $display("with linked and unlinked detection, hard and soft knees.");
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

[soft_knee_compressor.f]
src/skc_pkg.sv
src/skc_ctrl.sv
src/skc_datapath.sv
src/soft_knee_compressor.sv
tb/sv/soft_knee_compressor_checker.sv
tb/sv/soft_knee_compressor_test.sv
